@@ rtl/core/cshl_pkg.sv @@
`default_nettype none
package cshl_pkg;

    localparam int unsigned KeywordMaxLen = 8;
    localparam int unsigned KeywordCount  = 32;
    localparam int unsigned RomWords      = 32;
    localparam int unsigned RomWidth      = 9;

    typedef enum logic [2:0] {
        CLS_NORMAL  = 3'd0,
        CLS_LINECMT = 3'd1,
        CLS_BLKCMT  = 3'd2,
        CLS_STRING  = 3'd3,
        CLS_NUMBER  = 3'd4,
        CLS_KEYWORD = 3'd5
    } char_class_t;

    typedef enum logic [2:0] {
        MODE_FRESH   = 3'd0,
        MODE_LINECMT = 3'd1,
        MODE_STRING  = 3'd2,
        MODE_NUMBER  = 3'd3,
        MODE_WORD    = 3'd4,
        MODE_LONG    = 3'd5
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_present;
        logic       line_end;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_char_present;
        logic [2:0] char_class;
        logic       out_line_end;
        logic       comment_open;
        logic       run_last;
    } out_beat_t;

    typedef logic [RomWidth*8-1:0] rom_word_t;

    function automatic rom_word_t kw_rom(input logic [4:0] idx);
        rom_word_t w;
        w = '0;
        case (idx)
            5'd0:  w = rom_word_t'("if");
            5'd1:  w = rom_word_t'("else");
            5'd2:  w = rom_word_t'("for");
            5'd3:  w = rom_word_t'("while");
            5'd4:  w = rom_word_t'("do");
            5'd5:  w = rom_word_t'("switch");
            5'd6:  w = rom_word_t'("case");
            5'd7:  w = rom_word_t'("default");
            5'd8:  w = rom_word_t'("break");
            5'd9:  w = rom_word_t'("continue");
            5'd10: w = rom_word_t'("return");
            5'd11: w = rom_word_t'("struct");
            5'd12: w = rom_word_t'("typedef");
            5'd13: w = rom_word_t'("enum");
            5'd14: w = rom_word_t'("union");
            5'd15: w = rom_word_t'("static");
            5'd16: w = rom_word_t'("const");
            5'd17: w = rom_word_t'("volatile");
            5'd18: w = rom_word_t'("extern");
            5'd19: w = rom_word_t'("inline");
            5'd20: w = rom_word_t'("void");
            5'd21: w = rom_word_t'("char");
            5'd22: w = rom_word_t'("short");
            5'd23: w = rom_word_t'("int");
            5'd24: w = rom_word_t'("long");
            5'd25: w = rom_word_t'("float");
            5'd26: w = rom_word_t'("double");
            5'd27: w = rom_word_t'("signed");
            5'd28: w = rom_word_t'("unsigned");
            5'd29: w = rom_word_t'("size_t");
            5'd30: w = rom_word_t'("bool");
            5'd31: w = rom_word_t'("NULL");
            default: w = '0;
        endcase
        return w;
    endfunction

    // string literals are right aligned; byte i of the word holds char n-1-i (first char = 0), n the length
    function automatic logic [3:0] kw_len(input logic [4:0] idx);
        rom_word_t w;
        logic [3:0] n;
        w = kw_rom(idx);
        n = '0;
        for (int i = 0; i < RomWidth; i++) begin
            if (w[i*8 +: 8] != 8'd0) n = 4'(i + 1);
        end
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input logic [4:0] idx, input logic [3:0] pos);
        rom_word_t w;
        logic [3:0] n;
        logic [7:0] c;
        w = kw_rom(idx);
        n = kw_len(idx);
        c = 8'd0;
        for (int i = 0; i < RomWidth; i++) begin
            if (4'(i) + pos + 4'd1 == n) c = w[i*8 +: 8];
        end
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_wordch(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        logic r;
        case (c)
            8'd0, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, " ",
            ",", ".", "(", ")", "+", "-", "/", "*", "=", "~", "%", "<", ">",
            "[", "]", "{", "}", ";", ":", "&", "|", "^", "!", "?": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/cshl_kwmatch.sv @@
`default_nettype none
module cshl_kwmatch #(
    parameter int unsigned KEYWORD_MAX_LEN = cshl_pkg::KeywordMaxLen,
    parameter int unsigned KEYWORD_COUNT   = cshl_pkg::KeywordCount
) (
    input  wire logic [KEYWORD_MAX_LEN-1:0][7:0] word,
    input  wire logic [$clog2(KEYWORD_MAX_LEN+1)-1:0] word_len,
    output logic                                   hit
);
    import cshl_pkg::*;

    localparam int unsigned NumKw = (KEYWORD_COUNT < RomWords) ? KEYWORD_COUNT : RomWords;

    // independent compare per ROM entry, OR-reduced
    always_comb begin
        logic ok;
        hit = 1'b0;
        for (int k = 0; k < NumKw; k++) begin
            ok = (32'(kw_len(5'(k))) == 32'(word_len))
                 && (32'(kw_len(5'(k))) <= KEYWORD_MAX_LEN);
            for (int p = 0; p < KEYWORD_MAX_LEN; p++) begin
                if (p < 32'(word_len) && p < RomWidth) begin
                    if (word[p] != kw_char(5'(k), 4'(p))) ok = 1'b0;
                end
            end
            if (ok) hit = 1'b1;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/cshl_outq.sv @@
`default_nettype none
// Result queue: takes a burst of up to MAX_RES beats in a single push, drains one per cycle while m_ready is high.
module cshl_outq #(
    parameter int unsigned MAX_RES = cshl_pkg::KeywordMaxLen + 2,
    parameter int unsigned DEPTH   = 2 * (cshl_pkg::KeywordMaxLen + 2)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire cshl_pkg::out_beat_t [MAX_RES-1:0] push_beats,
    input  wire logic [$clog2(MAX_RES+1)-1:0] push_cnt,
    output logic [$clog2(DEPTH+1)-1:0]      free_cnt,
    output cshl_pkg::out_beat_t             m_beat,
    output logic                            m_valid,
    input  wire logic                       m_ready
);
    import cshl_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    out_beat_t        mem_reg [DEPTH];
    logic [AW-1:0]    rd_reg, rd_next;
    logic [AW-1:0]    wr_reg, wr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             pop;

    assign m_valid  = cnt_reg != '0;
    assign m_beat   = mem_reg[rd_reg];
    assign pop      = m_valid && m_ready;
    assign free_cnt = CW'(DEPTH) - cnt_reg;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input int unsigned b);
        logic [AW:0] s;
        s = (AW+1)'(a) + (AW+1)'(b);
        if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
        return s[AW-1:0];
    endfunction

    always_comb begin
        rd_next  = pop ? wrap_add(rd_reg, 1) : rd_reg;
        wr_next  = wrap_add(wr_reg, 32'(push_cnt));
        cnt_next = cnt_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (i < 32'(push_cnt)) mem_reg[wrap_add(wr_reg, i)] <= push_beats[i];
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/c_syntax_highlight_lexer.sv @@
`default_nettype none
// Channel | Ports                      | Beat
// input   | s_valid / s_ready / s_data | cshl_pkg::in_beat_t
// result  | m_valid / m_ready / m_data | cshl_pkg::out_beat_t
// config  | cfg_valid / cfg_ready / cfg_data | highlight_enable
// One input beat per cycle while s_ready is high; an accepted beat is first held in
// the input register, and its results (up to KEYWORD_MAX_LEN+2) are then written
// into the result queue, from which m_data is read; the queue drains one beat per
// cycle while m_ready is high. s_ready drops while the queue lacks room for the
// registered beat's results plus a worst-case burst. Synchronous active-low reset;
// highlight_enable resets to 1.
module c_syntax_highlight_lexer #(
    parameter int unsigned KEYWORD_MAX_LEN = cshl_pkg::KeywordMaxLen,
    parameter int unsigned KEYWORD_COUNT   = cshl_pkg::KeywordCount
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire cshl_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output cshl_pkg::out_beat_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data
);
    import cshl_pkg::*;

    localparam int unsigned MaxRes = KEYWORD_MAX_LEN + 2;
    localparam int unsigned Depth  = 2 * MaxRes;
    localparam int unsigned LW     = $clog2(KEYWORD_MAX_LEN + 1);
    localparam int unsigned RW     = $clog2(MaxRes + 1);
    localparam int unsigned FW     = $clog2(Depth + 1);

    logic            en_reg;
    logic            blk_reg, blk_next;
    lex_mode_t       mode_reg, mode_next;
    logic            dq_reg, dq_next;
    logic            esc_reg, esc_next;
    logic [7:0]      held_reg, held_next;
    logic            hv_reg, hv_next;
    logic            psep_reg, psep_next;
    logic            star_reg, star_next;
    logic [KEYWORD_MAX_LEN-1:0][7:0] wbuf_reg, wbuf_next;
    logic [LW-1:0]   wlen_reg, wlen_next;
    logic            wok_reg, wok_next;

    // registered input beat
    in_beat_t        in_reg;
    logic            iv_reg;

    // word buffer as extended by the current character
    logic [KEYWORD_MAX_LEN-1:0][7:0] wbuf_eol;
    logic [LW-1:0]   wlen_eol;
    logic            ext_eol;

    logic            kw_hit;
    out_beat_t [MaxRes-1:0] beats;
    logic [RW-1:0]   n;
    logic [FW-1:0]   free_cnt;

    assign cfg_ready = 1'b1;
    assign s_ready   = free_cnt >= FW'(MaxRes) + FW'(n);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg <= 1'b1;
        end else if (cfg_valid) begin
            en_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iv_reg <= 1'b0;
        end else begin
            iv_reg <= s_valid && s_ready;
        end
        in_reg <= s_data;
    end

    always_comb begin
        ext_eol = iv_reg && in_reg.char_present && !blk_reg && !hv_reg
                  && mode_reg == MODE_WORD && is_wordch(in_reg.char_code)
                  && 32'(wlen_reg) < KEYWORD_MAX_LEN;
        wbuf_eol = wbuf_reg;
        wlen_eol = wlen_reg;
        if (ext_eol) begin
            wbuf_eol[wlen_reg[$clog2(KEYWORD_MAX_LEN)-1:0]] = in_reg.char_code;
            wlen_eol = wlen_reg + 1'b1;
        end
    end

    cshl_kwmatch #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN), .KEYWORD_COUNT(KEYWORD_COUNT)) u_kw (
        .word(wbuf_eol), .word_len(wlen_eol), .hit(kw_hit)
    );

    always_comb begin
        logic [7:0] c;
        logic       pres, eol, kw, fresh;
        c    = in_reg.char_code;
        pres = iv_reg && in_reg.char_present;
        eol  = iv_reg && in_reg.line_end;
        blk_next = blk_reg; mode_next = mode_reg; dq_next = dq_reg; esc_next = esc_reg;
        held_next = held_reg; hv_next = hv_reg; psep_next = psep_reg;
        star_next = star_reg; wbuf_next = wbuf_reg; wlen_next = wlen_reg; wok_next = wok_reg;
        beats = '0;
        n = '0;
        fresh = 1'b0;
        kw = 1'b0;
        for (int i = 0; i < MaxRes; i++) beats[i].out_char_present = 1'b1;

        if (pres) begin
            if (blk_reg) begin
                beats[n].out_char = c; beats[n].char_class = CLS_BLKCMT; n = n + 1'b1;
                if (star_reg && c == "/") begin
                    blk_next = 1'b0; star_next = 1'b0;
                end else begin
                    star_next = c == "*";
                end
            end else if (hv_reg) begin
                hv_next = 1'b0;
                if (c == "/") begin
                    beats[0].out_char = held_reg; beats[0].char_class = CLS_LINECMT;
                    beats[1].out_char = c;        beats[1].char_class = CLS_LINECMT;
                    n = RW'(2); mode_next = MODE_LINECMT;
                end else if (c == "*") begin
                    beats[0].out_char = held_reg; beats[0].char_class = CLS_BLKCMT;
                    beats[1].out_char = c;        beats[1].char_class = CLS_BLKCMT;
                    n = RW'(2); blk_next = 1'b1; star_next = 1'b0; mode_next = MODE_FRESH;
                end else begin
                    beats[0].out_char = held_reg; beats[0].char_class = CLS_NORMAL;
                    n = RW'(1); fresh = 1'b1;
                end
            end else begin
                case (mode_reg)
                    MODE_LINECMT: begin
                        beats[0].out_char = c; beats[0].char_class = CLS_LINECMT; n = RW'(1);
                    end
                    MODE_STRING: begin
                        beats[0].out_char = c; beats[0].char_class = CLS_STRING; n = RW'(1);
                        if (esc_reg) esc_next = 1'b0;
                        else if (c == "\\") esc_next = 1'b1;
                        else if (c == (dq_reg ? 8'h22 : 8'h27)) mode_next = MODE_FRESH;
                    end
                    MODE_NUMBER: begin
                        if (is_digit(c) || c == ".") begin
                            beats[0].out_char = c; beats[0].char_class = CLS_NUMBER;
                            n = RW'(1);
                        end else begin
                            fresh = 1'b1;
                        end
                    end
                    MODE_WORD: begin
                        if (is_wordch(c)) begin
                            if (32'(wlen_reg) < KEYWORD_MAX_LEN) begin
                                wbuf_next[wlen_reg[$clog2(KEYWORD_MAX_LEN)-1:0]] = c;
                                wlen_next = wlen_reg + 1'b1;
                            end else begin
                                for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
                                    beats[i].out_char = wbuf_reg[i];
                                    beats[i].char_class = CLS_NORMAL;
                                end
                                beats[KEYWORD_MAX_LEN].out_char = c;
                                beats[KEYWORD_MAX_LEN].char_class = CLS_NORMAL;
                                n = RW'(KEYWORD_MAX_LEN + 1);
                                wlen_next = '0; mode_next = MODE_LONG;
                            end
                        end else begin
                            kw = wok_reg && is_sep(c) && kw_hit;
                            for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
                                beats[i].out_char = wbuf_reg[i];
                                beats[i].char_class = kw ? CLS_KEYWORD : CLS_NORMAL;
                            end
                            n = RW'(wlen_reg); wlen_next = '0; fresh = 1'b1;
                        end
                    end
                    MODE_LONG: begin
                        if (is_wordch(c)) begin
                            beats[0].out_char = c; beats[0].char_class = CLS_NORMAL;
                            n = RW'(1);
                        end else begin
                            fresh = 1'b1;
                        end
                    end
                    default: fresh = 1'b1;
                endcase
            end

            if (fresh) begin
                mode_next = MODE_FRESH;
                if (c == "/") begin
                    held_next = c; hv_next = 1'b1;
                end else if (c == 8'h22 || c == 8'h27) begin
                    beats[n].out_char = c; beats[n].char_class = CLS_STRING; n = n + 1'b1;
                    mode_next = MODE_STRING; dq_next = c == 8'h22; esc_next = 1'b0;
                end else if (is_digit(c) && psep_reg) begin
                    beats[n].out_char = c; beats[n].char_class = CLS_NUMBER; n = n + 1'b1;
                    mode_next = MODE_NUMBER;
                end else if (is_alpha(c) || c == "_") begin
                    wbuf_next[0] = c; wlen_next = LW'(1); wok_next = psep_reg;
                    mode_next = MODE_WORD;
                end else begin
                    beats[n].out_char = c; beats[n].char_class = CLS_NORMAL; n = n + 1'b1;
                end
            end
            psep_next = is_sep(c);
        end

        if (eol) begin
            // end of line acts on the state left by the character, if any
            if (hv_next) begin
                beats[n].out_char = held_next; beats[n].char_class = CLS_NORMAL;
                n = n + 1'b1; hv_next = 1'b0;
            end
            if (mode_next == MODE_WORD) begin
                // a word started by this character is one letter, never a keyword
                kw = wok_next && kw_hit && (!pres || ext_eol);
                for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
                    if (i < 32'(wlen_next)) begin
                        beats[n].out_char = wbuf_next[i];
                        beats[n].char_class = kw ? CLS_KEYWORD : CLS_NORMAL;
                        n = n + 1'b1;
                    end
                end
            end
            wlen_next = '0; mode_next = MODE_FRESH; esc_next = 1'b0; dq_next = 1'b0;
            star_next = 1'b0; psep_next = 1'b1;
            if (n == '0) begin
                beats[0].out_char_present = 1'b0; n = RW'(1);
            end
        end

        for (int i = 0; i < MaxRes; i++) begin
            if (!en_reg) beats[i].char_class = CLS_NORMAL;
            beats[i].run_last = (32'(n) == i + 1);
            beats[i].out_line_end = eol && beats[i].run_last;
            beats[i].comment_open = eol && beats[i].run_last && en_reg && blk_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_reg <= 1'b0; mode_reg <= MODE_FRESH; dq_reg <= 1'b0; esc_reg <= 1'b0;
            held_reg <= '0; hv_reg <= 1'b0; psep_reg <= 1'b1; star_reg <= 1'b0;
            wlen_reg <= '0; wok_reg <= 1'b0;
        end else begin
            blk_reg <= blk_next; mode_reg <= mode_next; dq_reg <= dq_next;
            esc_reg <= esc_next; held_reg <= held_next; hv_reg <= hv_next;
            psep_reg <= psep_next; star_reg <= star_next; wlen_reg <= wlen_next;
            wok_reg <= wok_next;
        end
        wbuf_reg <= wbuf_next;
    end

    cshl_outq #(.MAX_RES(MaxRes), .DEPTH(Depth)) u_q (
        .aclk(aclk), .aresetn(aresetn), .push_beats(beats), .push_cnt(n),
        .free_cnt(free_cnt), .m_beat(m_data), .m_valid(m_valid), .m_ready(m_ready)
    );
endmodule
`default_nettype wire

@@ rtl/core/cshl_checker.sv @@
`default_nettype none
module cshl_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire cshl_pkg::out_beat_t m_data
);
    import cshl_pkg::*;

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("m beat dropped");
    a_eol_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_line_end |-> m_data.run_last) else $error("line end not last");
    a_open_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.comment_open |-> m_data.out_line_end) else $error("comment_open");
    a_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.out_char_present |-> m_data.out_line_end && m_data.out_char == 8'd0)
        else $error("bare line end");
    a_cls: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.char_class <= CLS_KEYWORD) else $error("class range");
endmodule

bind c_syntax_highlight_lexer cshl_checker u_chk (
    .aclk(aclk), .aresetn(aresetn),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
`default_nettype wire
